[rtl/bidr_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the id remap table.
package bidr_pkg;

    localparam int USER_ENTRIES  = 64;
    localparam int GROUP_ENTRIES = 64;

    localparam int UAW = (USER_ENTRIES > 1) ? $clog2(USER_ENTRIES) : 1;
    localparam int GAW = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
    localparam int UCW = $clog2(USER_ENTRIES + 1);
    localparam int GCW = $clog2(GROUP_ENTRIES + 1);
    localparam int SCW = (UCW > GCW) ? UCW : GCW;

    localparam logic [31:0] NULL_ID = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_ADD_USER  = 3'd0,
        ACT_ADD_GROUP = 3'd1,
        ACT_MAP_FWD   = 3'd2,
        ACT_MAP_BWD   = 3'd3,
        ACT_CLEAR     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] host;
        logic [31:0] fs;
    } t_pair;

    typedef struct packed {
        logic    load;
        logic    map;
        logic    fwd;
        logic    wr_user;
        logic    wr_group;
        logic    clear;
        logic    scan_start;
        logic    scan_grp;
        logic    publish;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic a_null;
        logic b_null;
        logic user_full;
        logic group_full;
        logic done;
        logic hit;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/bidr_ctrl.sv]
// Controller state machine that sequences adds, clears and the two table scans of a request.
module bidr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [2:0]         i_action,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  bidr_pkg::t_dp_sts  i_sts,
    output logic               o_in_stall,
    output bidr_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_USCAN,
        S_GCHK,
        S_GSCAN,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    bidr_pkg::t_action r_act;
    bidr_pkg::t_status r_code, n_code;
    logic              r_allow;
    bidr_pkg::t_action in_act;

    assign in_act     = bidr_pkg::t_action'(i_action);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd      = '0;
        o_cmd.code = r_code;
        n_state    = r_state;
        n_code     = r_code;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                o_cmd.map  = (in_act == bidr_pkg::ACT_MAP_FWD) ||
                             (in_act == bidr_pkg::ACT_MAP_BWD);
                o_cmd.fwd  = (in_act == bidr_pkg::ACT_MAP_FWD);
                if (i_in_valid) begin
                    n_state = S_EXEC;
                    n_code  = bidr_pkg::ST_OK;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                case (r_act)
                    bidr_pkg::ACT_ADD_USER: begin
                        if (i_sts.user_full) begin
                            n_code = bidr_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_user = 1'b1;
                        end
                    end
                    bidr_pkg::ACT_ADD_GROUP: begin
                        if (i_sts.group_full) begin
                            n_code = bidr_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_group = 1'b1;
                        end
                    end
                    bidr_pkg::ACT_MAP_FWD, bidr_pkg::ACT_MAP_BWD: begin
                        if (i_sts.a_null) begin
                            n_state = S_GCHK;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_USCAN;
                        end
                    end
                    bidr_pkg::ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_USCAN: begin
                if (i_sts.done) begin
                    if (!i_sts.hit && !r_allow) begin
                        n_code  = bidr_pkg::ST_NOTFOUND;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_GCHK;
                    end
                end
            end
            S_GCHK: begin
                if (i_sts.b_null) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_grp   = 1'b1;
                    n_state          = S_GSCAN;
                end
            end
            S_GSCAN: begin
                if (i_sts.done) begin
                    if (!i_sts.hit && !r_allow) begin
                        n_code = bidr_pkg::ST_NOTFOUND;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= bidr_pkg::ST_OK;
            r_allow <= 1'b0;
            r_act   <= bidr_pkg::ACT_ADD_USER;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            if (i_cfg_we) begin
                r_allow <= i_cfg_data;
            end
            if (r_state == S_IDLE && i_in_valid) begin
                r_act <= in_act;
            end
        end
    end

endmodule

[rtl/bidr_dp.sv]
// Datapath with the user and group pair memories, fill counts, scan engine and result register.
module bidr_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_id_a,
    input  logic [31:0]        i_id_b,
    input  logic               i_out_stall,
    input  bidr_pkg::t_dp_cmd  i_cmd,
    output bidr_pkg::t_dp_sts  o_sts,
    output logic               o_out_valid,
    output logic [31:0]        o_user_id_out,
    output logic [31:0]        o_group_id_out,
    output logic [1:0]         o_status
);

    bidr_pkg::t_pair r_umem [bidr_pkg::USER_ENTRIES];
    bidr_pkg::t_pair r_gmem [bidr_pkg::GROUP_ENTRIES];
    bidr_pkg::t_pair r_urd, r_grd, rd_pair;

    logic [bidr_pkg::UCW-1:0] r_ucnt;
    logic [bidr_pkg::GCW-1:0] r_gcnt;
    logic [bidr_pkg::SCW-1:0] r_left, rd_addr;

    logic        r_busy, r_pend, r_tsel, r_fwd;
    logic [31:0] r_key, r_a, r_b, r_uo, r_go;
    logic [31:0] cmp_key, cmp_val;
    logic        hit_now, miss_now;

    logic        r_out_valid;
    logic [31:0] r_out_uo, r_out_go;
    logic [1:0]  r_out_st;

    assign rd_addr  = r_left - bidr_pkg::SCW'(1);
    assign rd_pair  = r_tsel ? r_grd : r_urd;
    assign cmp_key  = r_fwd ? rd_pair.host : rd_pair.fs;
    assign cmp_val  = r_fwd ? rd_pair.fs : rd_pair.host;
    assign hit_now  = r_busy && r_pend && (cmp_key == r_key);
    assign miss_now = r_busy && !r_pend && (r_left == '0);

    always_comb begin
        o_sts            = '0;
        o_sts.a_null     = (r_a == bidr_pkg::NULL_ID);
        o_sts.b_null     = (r_b == bidr_pkg::NULL_ID);
        o_sts.user_full  = (r_ucnt == bidr_pkg::UCW'(bidr_pkg::USER_ENTRIES));
        o_sts.group_full = (r_gcnt == bidr_pkg::GCW'(bidr_pkg::GROUP_ENTRIES));
        o_sts.done       = hit_now || miss_now;
        o_sts.hit        = hit_now;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_user) begin
            r_umem[r_ucnt[bidr_pkg::UAW-1:0]] <= {r_a, r_b};
        end
        r_urd <= r_umem[rd_addr[bidr_pkg::UAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_group) begin
            r_gmem[r_gcnt[bidr_pkg::GAW-1:0]] <= {r_a, r_b};
        end
        r_grd <= r_gmem[rd_addr[bidr_pkg::GAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ucnt      <= '0;
            r_gcnt      <= '0;
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_left      <= '0;
            r_tsel      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_ucnt <= '0;
                r_gcnt <= '0;
            end else begin
                if (i_cmd.wr_user) begin
                    r_ucnt <= r_ucnt + bidr_pkg::UCW'(1);
                end
                if (i_cmd.wr_group) begin
                    r_gcnt <= r_gcnt + bidr_pkg::GCW'(1);
                end
            end
            if (i_cmd.scan_start) begin
                r_busy <= 1'b1;
                r_pend <= 1'b0;
                r_tsel <= i_cmd.scan_grp;
                r_left <= i_cmd.scan_grp ? bidr_pkg::SCW'(r_gcnt) : bidr_pkg::SCW'(r_ucnt);
            end else if (r_busy) begin
                if (hit_now || miss_now) begin
                    r_busy <= 1'b0;
                end else if (r_left != '0) begin
                    r_left <= rd_addr;
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= i_id_a;
            r_b   <= i_id_b;
            r_fwd <= i_cmd.fwd;
            r_uo  <= i_cmd.map ? i_id_a : '0;
            r_go  <= i_cmd.map ? i_id_b : '0;
        end else if (hit_now) begin
            if (r_tsel) begin
                r_go <= cmp_val;
            end else begin
                r_uo <= cmp_val;
            end
        end
        if (i_cmd.scan_start) begin
            r_key <= i_cmd.scan_grp ? r_b : r_a;
        end
        if (i_cmd.publish) begin
            r_out_uo <= r_uo;
            r_out_go <= r_go;
            r_out_st <= i_cmd.code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_user_id_out  = r_out_uo;
    assign o_group_id_out = r_out_go;
    assign o_status       = r_out_st;

`ifndef SYNTH
    a_ucnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt <= bidr_pkg::UCW'(bidr_pkg::USER_ENTRIES))
        else $error("user fill count beyond table depth");
    a_gcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gcnt <= bidr_pkg::GCW'(bidr_pkg::GROUP_ENTRIES))
        else $error("group fill count beyond table depth");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_ucnt == '0) && (r_gcnt == '0))
        else $error("clear did not empty both tables");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_start |-> !r_busy)
        else $error("scan started while a scan is running");
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> (!r_out_valid || !i_out_stall))
        else $error("result published over an unread result");
`endif

endmodule

[rtl/bidirectional_id_remap_table.sv]
// Top level of the bidirectional user and group id remap table.
//
//  Channel | Valid       | Stall       | Payload
//  --------+-------------+-------------+---------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_action, i_id_a, i_id_b
//  out     | o_out_valid | i_out_stall | o_user_id_out, o_group_id_out, o_status
//  cfg     | i_cfg_we    | none        | i_cfg_data (allow_unmapped)
//
// Add, clear and unused actions go from S_EXEC to S_FIN, which publishes their result.
// A translate scans the user table and then the group table, newest entry first,
// one compare per cycle, through each table's single read port with registered read data.
// A null id skips its scan, and a user miss without allow_unmapped skips the group scan.
// Reset empties both tables and clears allow_unmapped; no clearing pass is needed.
// One request is in work at a time; it may be taken while an earlier result waits
// under i_out_stall, and it then holds until the output register frees up.
module bidirectional_id_remap_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_id_a,
    input  logic [31:0] i_id_b,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_user_id_out,
    output logic [31:0] o_group_id_out,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data
);

    bidr_pkg::t_dp_cmd cmd;
    bidr_pkg::t_dp_sts sts;

    bidr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    bidr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_id_a         (i_id_a),
        .i_id_b         (i_id_b),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_user_id_out  (o_user_id_out),
        .o_group_id_out (o_group_id_out),
        .o_status       (o_status)
    );

endmodule
